[hdl/tse_pkg.sv]
package tse_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 1;
  localparam int unsigned GLYPH_MAX  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_ALL       = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_ENDS        = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // One queued item: optional line number prefix plus 1..4 glyph bytes.
  typedef struct packed {
    logic                      has_num;
    logic [2:0]                glyph_cnt;
    logic [GLYPH_MAX-1:0][7:0] glyph;
  } item_desc_t;

  localparam logic [7:0] CH_TAB        = 8'd9;
  localparam logic [7:0] CH_NL         = 8'd10;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_DOLLAR     = 8'd36;
  localparam logic [7:0] CH_DASH       = 8'd45;
  localparam logic [7:0] CH_ZERO       = 8'd48;
  localparam logic [7:0] CH_QMARK      = 8'd63;
  localparam logic [7:0] CH_I          = 8'd73;
  localparam logic [7:0] CH_M          = 8'd77;
  localparam logic [7:0] CH_CARET      = 8'd94;
  localparam logic [7:0] CH_DEL        = 8'd127;
  localparam logic [7:0] CH_FF         = 8'd255;
  localparam logic [7:0] CTRL_END      = 8'd32;
  localparam logic [7:0] CTRL_OFS      = 8'd64;
  localparam logic [7:0] HIGH_START    = 8'd128;
  localparam logic [7:0] HIGH_CTRL_END = 8'd160;

endpackage

[hdl/tse_in_if.sv]
interface tse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[hdl/tse_out_if.sv]
interface tse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[hdl/tse_front.sv]
module tse_front #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tse_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  input  logic [7:0]                        in_byte_i,
  output logic                              in_ready_o,
  input  logic                              full_i,
  output logic                              push_o,
  output tse_pkg::item_desc_t               desc_o,
  output logic [NUMBER_DIGITS-1:0][7:0]     num_o
);

  logic [1:0]                    run_q, run_d;
  logic [NUMBER_DIGITS-1:0][3:0] bcd_q, bcd_d, bcd_inc;
  logic                          accept, is_nl, line_start, squeezed, numbered;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign is_nl      = (in_byte_i == tse_pkg::CH_NL);
  assign line_start = (run_q != 2'd0);

  always_comb begin
    if (is_nl) begin
      run_d = (run_q == 2'd3) ? run_q : run_q + 2'd1;
    end else begin
      run_d = 2'd0;
    end
  end

  assign squeezed = cfg_i.squeeze_blank & (run_d == 2'd3);
  assign numbered = line_start & (cfg_i.number_nonblank ? ~is_nl : cfg_i.number_all);
  assign push_o   = accept & ~squeezed;

  // Saturating BCD increment and right-aligned rendering of the new value.
  always_comb begin : counter
    logic carry;
    logic all_nine;
    logic zero_above;
    all_nine = 1'b1;
    carry    = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (bcd_q[i] != 4'd9) all_nine = 1'b0;
      if (carry) begin
        if (bcd_q[i] == 4'd9) begin
          bcd_inc[i] = 4'd0;
        end else begin
          bcd_inc[i] = bcd_q[i] + 4'd1;
          carry      = 1'b0;
        end
      end else begin
        bcd_inc[i] = bcd_q[i];
      end
    end
    if (all_nine) bcd_inc = bcd_q;
    zero_above = 1'b1;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      zero_above = zero_above & (bcd_inc[NUMBER_DIGITS-1-k] == 4'd0);
      if (zero_above && (k != NUMBER_DIGITS - 1)) begin
        num_o[k] = tse_pkg::CH_SPACE;
      end else begin
        num_o[k] = tse_pkg::CH_ZERO | {4'd0, bcd_inc[NUMBER_DIGITS-1-k]};
      end
    end
  end

  assign bcd_d = (push_o && numbered) ? bcd_inc : bcd_q;

  always_comb begin
    desc_o.has_num   = numbered;
    desc_o.glyph     = '0;
    desc_o.glyph_cnt = 3'd1;
    desc_o.glyph[0]  = in_byte_i;
    if (cfg_i.show_nonprinting && !is_nl && in_byte_i != tse_pkg::CH_TAB) begin
      if (in_byte_i < tse_pkg::CTRL_END) begin
        desc_o.glyph_cnt = 3'd2;
        desc_o.glyph[0]  = tse_pkg::CH_CARET;
        desc_o.glyph[1]  = in_byte_i + tse_pkg::CTRL_OFS;
      end else if (in_byte_i == tse_pkg::CH_DEL) begin
        desc_o.glyph_cnt = 3'd2;
        desc_o.glyph[0]  = tse_pkg::CH_CARET;
        desc_o.glyph[1]  = tse_pkg::CH_QMARK;
      end else if (in_byte_i >= tse_pkg::HIGH_START) begin
        desc_o.glyph[0] = tse_pkg::CH_M;
        desc_o.glyph[1] = tse_pkg::CH_DASH;
        if (in_byte_i < tse_pkg::HIGH_CTRL_END) begin
          desc_o.glyph_cnt = 3'd4;
          desc_o.glyph[2]  = tse_pkg::CH_CARET;
          desc_o.glyph[3]  = in_byte_i - tse_pkg::CTRL_OFS;
        end else if (in_byte_i != tse_pkg::CH_FF) begin
          desc_o.glyph_cnt = 3'd3;
          desc_o.glyph[2]  = in_byte_i - tse_pkg::HIGH_START;
        end else begin
          desc_o.glyph_cnt = 3'd4;
          desc_o.glyph[2]  = tse_pkg::CH_CARET;
          desc_o.glyph[3]  = tse_pkg::CH_QMARK;
        end
      end
    end else if (cfg_i.show_tabs && in_byte_i == tse_pkg::CH_TAB) begin
      desc_o.glyph_cnt = 3'd2;
      desc_o.glyph[0]  = tse_pkg::CH_CARET;
      desc_o.glyph[1]  = tse_pkg::CH_I;
    end else if (cfg_i.show_ends && is_nl) begin
      desc_o.glyph_cnt = 3'd2;
      desc_o.glyph[0]  = tse_pkg::CH_DOLLAR;
      desc_o.glyph[1]  = tse_pkg::CH_NL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 2'd1;
      bcd_q <= '0;
    end else if (accept) begin
      run_q <= run_d;
      bcd_q <= bcd_d;
    end
  end

endmodule

[hdl/tse_fifo.sv]
module tse_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    if (do_pop)  rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    if (!do_push && do_pop) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

[hdl/tse_back.sv]
module tse_back #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tse_pkg::item_desc_t           desc_i,
  input  logic [NUMBER_DIGITS-1:0][7:0] num_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_o
);

  localparam int unsigned POS_W = $clog2(NUMBER_DIGITS + 1 + tse_pkg::GLYPH_MAX + 1);

  logic [POS_W-1:0] pos_q, pos_d, off, rel, last_pos;
  logic [1:0]       gsel;
  logic             fire;

  assign out_valid_o = ~empty_i;
  assign fire        = out_valid_o & out_ready_i;
  assign off         = desc_i.has_num ? POS_W'(NUMBER_DIGITS + 1) : '0;
  assign rel         = pos_q - off;
  assign gsel        = rel[1:0];
  assign last_pos    = off + POS_W'(desc_i.glyph_cnt) - POS_W'(1);
  assign last_o      = (pos_q == last_pos);
  assign pop_o       = fire & last_o;
  assign pos_d       = last_o ? '0 : pos_q + POS_W'(1);

  // Prefix digits, then tab, then the glyph bytes.
  always_comb begin
    out_byte_o = desc_i.glyph[gsel];
    if (desc_i.has_num) begin
      if (pos_q == POS_W'(NUMBER_DIGITS)) begin
        out_byte_o = tse_pkg::CH_TAB;
      end else begin
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
          if (pos_q == POS_W'(i)) out_byte_o = num_i[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (fire) begin
      pos_q <= pos_d;
    end
  end

endmodule

[hdl/text_stream_escaper.sv]
// Text stream escaper: one text byte in per item, its rendering out as a run
// of bytes with last_of_run on the final one (a squeezed blank line gives no
// run). Input is taken every cycle while the two-entry item queue has room;
// the output port sends one byte per cycle while out_if.ready is high, and
// an item renders to 1 to NUMBER_DIGITS+5 bytes, so that output byte rate
// sets the sustained throughput. The first byte of a run is offered once its
// item, registered into the item queue, reaches the head of that queue.
// Configuration registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i; indexes beyond show_nonprinting are ignored.
module text_stream_escaper #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  tse_in_if.sink                           in_if,
  tse_out_if.source                        out_if,
  input  logic                             cfg_we_i,
  input  logic [tse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tse_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned NUM_W  = 8 * NUMBER_DIGITS;
  localparam int unsigned DESC_W = $bits(tse_pkg::item_desc_t);
  localparam int unsigned FIFO_W = DESC_W + NUM_W;

  tse_pkg::cfg_t                 cfg_q;
  tse_pkg::item_desc_t           push_desc, head_desc;
  logic [NUMBER_DIGITS-1:0][7:0] push_num, head_num;
  logic                          push, pop, full, empty;
  logic [FIFO_W-1:0]             head_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (tse_pkg::cfg_idx_e'(cfg_idx_i))
        tse_pkg::CFG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data_i[0];
        tse_pkg::CFG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data_i[0];
        tse_pkg::CFG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data_i[0];
        tse_pkg::CFG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data_i[0];
        tse_pkg::CFG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data_i[0];
        tse_pkg::CFG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tse_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_if.valid),
    .in_byte_i  (in_if.in_byte),
    .in_ready_o (in_if.ready),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (push_desc),
    .num_o      (push_num)
  );

  tse_fifo #(.WIDTH(FIFO_W), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_desc, push_num}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_data),
    .empty_o (empty)
  );

  assign head_desc = tse_pkg::item_desc_t'(head_data[FIFO_W-1:NUM_W]);
  assign head_num  = head_data[NUM_W-1:0];

  tse_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (head_desc),
    .num_i       (head_num),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_byte_o  (out_if.out_byte),
    .last_o      (out_if.last_of_run)
  );

endmodule

[hdl/tse_checker.sv]
module tse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  logic out_fire;
  assign out_fire = out_valid_i & out_ready_i;

  // A stalled output item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("output item changed while stalled");

  // A newline is always the final byte of its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_byte_i == tse_pkg::CH_NL |-> out_last_i)
    else $error("newline not last of run");

  // A caret inside a run is followed by its control letter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_byte_i == tse_pkg::CH_CARET && !out_last_i |=>
      out_valid_i && out_byte_i >= tse_pkg::CH_QMARK && out_byte_i <= 8'd95)
    else $error("caret not followed by control letter");

  // M inside a run opens the meta prefix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_byte_i == tse_pkg::CH_M && !out_last_i |=>
      out_valid_i && out_byte_i == tse_pkg::CH_DASH && !out_last_i)
    else $error("meta prefix broken");

endmodule

bind text_stream_escaper tse_checker u_tse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_byte_i  (out_if.out_byte),
  .out_last_i  (out_if.last_of_run)
);
